// ===== hdl/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg: shared types and constants of the LED strip effect engine.
// Holds the strip size, the register and operation codes and the sweep states.
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int NumLeds  = 128;
	localparam int IdxW     = $clog2(NumLeds);
	localparam int PosW     = $clog2(NumLeds + 1);
	localparam int LevelW   = 5;
	localparam int ColorW   = 24;
	localparam logic [LevelW-1:0] LevelMax   = 5'd31;
	localparam logic [LevelW-1:0] LevelReset = 5'd10;
	localparam logic [7:0] WordHeader = 8'he0;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_APPLY = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_DARK   = 2'd0,
		MODE_STATIC = 2'd1,
		MODE_MOVING = 2'd2,
		MODE_FADE   = 2'd3
	} mode_t;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_COLOR     = 3'd1;
	localparam logic [2:0] REG_LEVEL     = 3'd2;
	localparam logic [2:0] REG_SPOTSTART = 3'd3;
	localparam logic [2:0] REG_PEAK      = 3'd4;
	localparam logic [2:0] REG_SPOTINT   = 3'd5;
	localparam logic [2:0] REG_FADEINT   = 3'd6;

	// Kind of sweep the walker performs over the level memory.
	typedef enum logic [2:0] {
		SW_FILL,
		SW_DRAW,
		SW_FADEOUT,
		SW_FADEIN,
		SW_CLEAR
	} sweep_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_READ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		sweep_t             kind;
		logic [LevelW-1:0]  fill;
		logic [PosW-1:0]    pos;
		logic [LevelW-1:0]  peak;
	} sweep_cmd_t;

	typedef struct packed {
		logic               done;
		logic [LevelW-1:0]  last_level;
		logic [LevelW-1:0]  first_level;
	} sweep_sts_t;

endpackage

// ===== hdl/led_strip_effect_engine.sv =====
// ----------------------------------------------------------------------------
// led_strip_effect_engine: brightness store and effect sequencer for a strip.
// Runs fade and moving-spot effects and returns APA102 frame words.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_axis group. tdata carries operation (bits 1:0),
// led_index (8:2) and random_color (32:9). Each item returns exactly one
// result on m_axis: tdata holds frame_word (31:0) and redrawn (32).
// Registers are to be written through cfg_we/cfg_idx/cfg_data only while the
// block is idle; the block itself does not enforce this. A tick that runs a
// step and an apply outside fade mode walk every LED through one shared level
// unit, one LED per cycle. Other items pass through the read state without a
// walk. Only one item is in flight; s_axis_tready is low from acceptance until
// the result transaction completes. After reset a clearing pass loads every
// level with 10; no item is accepted meanwhile, but configuration writes are
// taken. When the receiver stalls, the result holds in the output register and
// no new item is accepted.
// ----------------------------------------------------------------------------
module led_strip_effect_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // operation, led_index, random_color
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // frame_word, redrawn
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data
);
	import lse_pkg::*;

	logic [1:0]        mode_q;
	logic [ColorW-1:0] scolor_q;
	logic [LevelW-1:0] slevel_q;
	logic [6:0]        sstart_q;
	logic [LevelW-1:0] peak_q;
	logic [6:0]        sint_q;
	logic [9:0]        fint_q;

	logic [ColorW-1:0] color_q;
	logic [9:0]        elapsed_q;
	logic              up_q;
	logic              fin_q;
	logic              fout_q;
	logic [PosW-1:0]   pos_q;
	logic [LevelW-1:0] lvl0_q;

	state_t            state_q, state_d;
	sweep_t            kind_q;
	logic [31:0]       word_q;
	logic              redrawn_q;
	logic              rvalid_q;

	sweep_cmd_t        cmd;
	sweep_sts_t        sts;
	logic [LevelW-1:0] rd_level;

	logic [1:0]        op;
	logic [6:0]        in_idx;
	logic [ColorW-1:0] in_rnd;
	logic              accept;
	logic [9:0]        el_inc;
	logic [LevelW-1:0] fcur;
	logic              fup;
	logic              fload;
	logic [PosW:0]     pos_nx;

	assign op     = s_axis_tdata[1:0];
	assign in_idx = s_axis_tdata[8:2];
	assign in_rnd = s_axis_tdata[32:9];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign el_inc = (elapsed_q < 10'd1023) ? elapsed_q + 1'b1 : elapsed_q;
	assign pos_nx = {1'b0, pos_q} + 1'b1;

	// Fade step on the cached level of LED 0. A new color is taken only when
	// the falling ramp reaches zero.
	always_comb begin
		fcur  = lvl0_q;
		fup   = up_q;
		fload = 1'b0;
		if (fup) begin
			fcur = fcur + 1'b1;
			if (fcur == LevelMax) fup = 1'b0;
		end
		if (!fup) begin
			fcur = fcur - 1'b1;
			if (fcur == '0) begin
				fup   = 1'b1;
				fload = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_STATIC;
			scolor_q <= '0;
			slevel_q <= LevelReset;
			sstart_q <= '0;
			peak_q   <= 5'd6;
			sint_q   <= 7'd50;
			fint_q   <= 10'd50;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:      mode_q   <= cfg_data[1:0];
				REG_COLOR:     scolor_q <= cfg_data;
				REG_LEVEL:     slevel_q <= cfg_data[4:0];
				REG_SPOTSTART: sstart_q <= cfg_data[6:0];
				REG_PEAK:      peak_q   <= cfg_data[4:0];
				REG_SPOTINT:   sint_q   <= cfg_data[6:0];
				REG_FADEINT:   fint_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.done) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = cmd.start ? ST_SWEEP : ST_READ;
			ST_SWEEP: if (sts.done) state_d = ST_OUT;
			ST_READ:  state_d = ST_OUT;
			ST_OUT:   if (m_axis_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs and the sweep command decode.
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = (state_q == ST_OUT);
		cmd = '0;
		cmd.kind = SW_FILL;
		cmd.pos  = pos_q;
		cmd.peak = peak_q;
		if (accept) begin
			if (op == OP_TICK) begin
				if (mode_q == MODE_FADE && el_inc >= fint_q) begin
					cmd.start = 1'b1;
					cmd.fill  = fcur;
				end else if (mode_q == MODE_MOVING && sint_q != '0 && el_inc >= 10'(sint_q)) begin
					cmd.start = 1'b1;
					if (fout_q) cmd.kind = SW_FADEOUT;
					else if (fin_q) cmd.kind = SW_FADEIN;
					else begin
						cmd.kind = SW_DRAW;
						cmd.pos  = (pos_nx >= (PosW+1)'(NumLeds)) ? PosW'(NumLeds) : pos_nx[PosW-1:0];
					end
				end
			end else if (op == OP_APPLY) begin
				cmd.start = (mode_q != MODE_FADE);
				if (mode_q == MODE_STATIC) cmd.fill = slevel_q;
				if (mode_q == MODE_MOVING) begin
					cmd.kind = SW_DRAW;
					cmd.pos  = PosW'(sstart_q);
				end
			end
		end
	end

	lse_level_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_en    (accept),
		.rd_idx   (in_idx[IdxW-1:0]),
		.rd_level (rd_level),
		.sts      (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			color_q   <= '0;
			elapsed_q <= '0;
			up_q      <= 1'b1;
			fin_q     <= 1'b0;
			fout_q    <= 1'b0;
			pos_q     <= '0;
			lvl0_q    <= LevelReset;
			kind_q    <= SW_CLEAR;
			word_q    <= '0;
			redrawn_q <= 1'b0;
			rvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				word_q    <= '0;
				redrawn_q <= cmd.start;
				kind_q    <= cmd.kind;
				rvalid_q  <= (op == OP_READ) && ({1'b0, in_idx} < 8'(NumLeds));
				if (op == OP_TICK) begin
					elapsed_q <= cmd.start ? '0 : el_inc;
					if (cmd.start && mode_q == MODE_FADE) begin
						up_q <= fup;
						if (fload) color_q <= in_rnd;
					end
					if (cmd.start && cmd.kind == SW_DRAW) begin
						pos_q <= cmd.pos;
						if (pos_nx >= (PosW+1)'(NumLeds)) fout_q <= 1'b1;
					end
				end else if (op == OP_APPLY) begin
					if (mode_q == MODE_STATIC) color_q <= scolor_q;
					if (mode_q == MODE_MOVING) pos_q <= cmd.pos;
				end
			end
			if (state_q == ST_READ && rvalid_q)
				word_q <= {WordHeader | 8'(rd_level), color_q[7:0], color_q[15:8], color_q[23:16]};
			if (sts.done) begin
				lvl0_q <= sts.first_level;
				if (state_q == ST_SWEEP && kind_q == SW_FADEOUT && sts.last_level == '0) begin
					fout_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				if (state_q == ST_SWEEP && kind_q == SW_FADEIN && sts.first_level == peak_q) begin
					pos_q <= '0;
					fin_q <= 1'b0;
				end
			end
		end
	end

	assign m_axis_tdata = {7'd0, redrawn_q, word_q};

endmodule

// ===== hdl/lse_level_walker.sv =====
// ----------------------------------------------------------------------------
// lse_level_walker: level memory and the sweep unit that rewrites it.
// One shared compare/subtract unit processes one LED each cycle.
// ----------------------------------------------------------------------------
module lse_level_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lse_pkg::sweep_cmd_t          cmd,
	input  logic                         rd_en,
	input  logic [lse_pkg::IdxW-1:0]     rd_idx,
	output logic [lse_pkg::LevelW-1:0]   rd_level,
	output lse_pkg::sweep_sts_t          sts
);
	import lse_pkg::*;

	logic [LevelW-1:0] mem [NumLeds];
	logic              busy_q;
	logic              rd_phase_q;
	logic              stop_q;
	sweep_t            kind_q;
	logic [LevelW-1:0] fill_q;
	logic [PosW-1:0]   pos_q;
	logic [LevelW-1:0] peak_q;
	logic [IdxW-1:0]   idx_q;
	logic [LevelW-1:0] cur_q;
	logic [LevelW-1:0] last_q;
	logic [LevelW-1:0] first_q;
	logic              done_q;

	logic [PosW-1:0]   spot_dist;
	logic [LevelW-1:0] new_lv;
	logic              wr_en;
	logic              last_idx;

	assign last_idx = (idx_q == IdxW'(NumLeds - 1));

	// Distance of the current LED from the spot, then the shared compare.
	always_comb begin
		spot_dist = ({1'b0, idx_q} >= pos_q) ? ({1'b0, idx_q} - pos_q)
			: (pos_q - {1'b0, idx_q});
		new_lv = cur_q;
		wr_en  = 1'b1;
		case (kind_q)
			SW_FILL, SW_CLEAR: new_lv = fill_q;
			SW_DRAW: new_lv = (spot_dist >= PosW'(peak_q)) ? '0
				: (peak_q - LevelW'(spot_dist));
			SW_FADEOUT: new_lv = (cur_q != '0) ? cur_q - 1'b1 : cur_q;
			SW_FADEIN: begin
				new_lv = cur_q + 1'b1;
				wr_en  = !stop_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (busy_q && !rd_phase_q && wr_en) mem[idx_q] <= new_lv;
		if (rd_en) rd_level <= mem[rd_idx];
		cur_q <= (cmd.start || (busy_q && !rd_phase_q)) ? mem[cmd.start ? '0 : idx_q + 1'b1]
			: mem[idx_q];
	end

	// Sweep: fetch cycle, then one write per LED with the next read overlapped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			rd_phase_q <= 1'b1;
			kind_q     <= SW_CLEAR;
			fill_q     <= LevelReset;
			idx_q      <= '0;
			stop_q     <= 1'b0;
			done_q     <= 1'b0;
			pos_q      <= '0;
			peak_q     <= '0;
			last_q     <= '0;
			first_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q     <= 1'b1;
				rd_phase_q <= 1'b1;
				kind_q     <= cmd.kind;
				fill_q     <= cmd.fill;
				pos_q      <= cmd.pos;
				peak_q     <= cmd.peak;
				idx_q      <= '0;
				stop_q     <= 1'b0;
			end else if (busy_q) begin
				if (rd_phase_q) begin
					rd_phase_q <= 1'b0;
				end else begin
					if (kind_q == SW_FADEIN && cur_q == '0) stop_q <= 1'b1;
					if (idx_q == '0) first_q <= wr_en ? new_lv : cur_q;
					if (last_idx) begin
						last_q <= wr_en ? new_lv : cur_q;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
		end
	end

	assign sts.done        = done_q;
	assign sts.last_level  = last_q;
	assign sts.first_level = first_q;

endmodule

// ===== verif/tb_led_strip_effect_engine.sv =====
// ----------------------------------------------------------------------------
// tb_led_strip_effect_engine: self-checking bench for the LED strip effect engine.
// Streams ticks, applies and reads through the block, predicts every result
// with an internal model of the level store and the sweep, and compares.
// ----------------------------------------------------------------------------
module tb_led_strip_effect_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import lse_pkg::*;

	typedef struct packed {
		logic [31:0] frame_word;
		logic        redrawn;
	} strip_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [23:0] cfg_data;

	led_strip_effect_engine DUT (.*);

	// Predictor copy of the configuration.
	mode_t       cur_mode;
	logic [23:0] cur_color;
	logic [4:0]  cur_static_level;
	logic [6:0]  cur_spot_start;
	logic [4:0]  cur_peak;
	logic [6:0]  cur_spot_int;
	logic [9:0]  cur_fade_int;

	// Predictor copy of the strip state.
	logic [4:0]  levels [NumLeds];
	logic [23:0] strip_rgb;
	logic [9:0]  ms_count;
	logic        ramp_up;
	logic        in_fade_in;
	logic        in_fade_out;
	int          spot_at;

	strip_result_t pending_results[$];
	int  mismatches;
	int  idle_cycles;
	bit  rx_hold;       // receiver hold-off request
	bit  rx_never_stall;
	bit  tx_no_gaps;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void redraw_spot();
		int d;
		for (int i = 0; i < NumLeds; i++) begin
			d = (i >= spot_at) ? i - spot_at : spot_at - i;
			levels[i] = (d >= cur_peak) ? 5'd0 : 5'(cur_peak - d);
		end
	endfunction

	function automatic void advance_spot();
		if (in_fade_out) begin
			for (int i = 0; i < NumLeds; i++)
				if (levels[i] != 0) levels[i] = levels[i] - 5'd1;
			if (levels[NumLeds-1] == 0) begin
				in_fade_out = 1'b0;
				in_fade_in = 1'b1;
			end
			return;
		end
		if (in_fade_in) begin
			logic [4:0] old;
			for (int i = 0; i < NumLeds; i++) begin
				old = levels[i];
				levels[i] = old + 5'd1;
				if (old == 0) break;
			end
			if (levels[0] == cur_peak) begin
				spot_at = 0;
				in_fade_in = 1'b0;
			end
			return;
		end
		spot_at++;
		if (spot_at >= NumLeds) begin
			spot_at = NumLeds;
			in_fade_out = 1'b1;
		end
		redraw_spot();
	endfunction

	function automatic void advance_fade(input logic [23:0] rnd);
		logic [4:0] lv;
		lv = levels[0];
		if (ramp_up) begin
			lv = lv + 5'd1;
			if (lv == LevelMax) ramp_up = 1'b0;
		end
		if (!ramp_up) begin
			lv = lv - 5'd1;
			if (lv == 0) begin
				ramp_up = 1'b1;
				strip_rgb = rnd;
			end
		end
		for (int i = 0; i < NumLeds; i++) levels[i] = lv;
	endfunction

	// Works out the result of one item and updates the predicted strip.
	function automatic strip_result_t predict_strip(input op_t op, input logic [6:0] idx,
			input logic [23:0] rnd);
		strip_result_t r;
		r = '0;
		case (op)
			OP_TICK: begin
				if (ms_count < 10'd1023) ms_count++;
				if (cur_mode == MODE_FADE) begin
					if (ms_count >= cur_fade_int) begin
						ms_count = 0;
						advance_fade(rnd);
						r.redrawn = 1'b1;
					end
				end else if (cur_mode == MODE_MOVING && cur_spot_int != 0) begin
					if (ms_count >= 10'(cur_spot_int)) begin
						ms_count = 0;
						advance_spot();
						r.redrawn = 1'b1;
					end
				end
			end
			OP_APPLY: begin
				case (cur_mode)
					MODE_DARK: begin
						for (int i = 0; i < NumLeds; i++) levels[i] = 5'd0;
						r.redrawn = 1'b1;
					end
					MODE_STATIC: begin
						for (int i = 0; i < NumLeds; i++) levels[i] = cur_static_level;
						strip_rgb = cur_color;
						r.redrawn = 1'b1;
					end
					MODE_MOVING: begin
						spot_at = cur_spot_start;
						redraw_spot();
						r.redrawn = 1'b1;
					end
					default: ;
				endcase
			end
			OP_READ: begin
				if (idx < NumLeds)
					r.frame_word = {WordHeader | 8'(levels[idx]), strip_rgb[7:0],
						strip_rgb[15:8], strip_rgb[23:16]};
			end
			default: ;
		endcase
		return r;
	endfunction

	// Sends one transaction, leaving valid high when the next one follows at once.
	task automatic send_item(input op_t op, input logic [6:0] idx, input logic [23:0] rnd);
		int gap;
		gap = tx_no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, rnd, idx, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(predict_strip(op, idx, rnd));
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain_results();
		stop_sending();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (NumLeds + 10) @(posedge clk);
	endtask

	// Register write, only issued while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODE:      cur_mode = mode_t'(val[1:0]);
			REG_COLOR:     cur_color = val;
			REG_LEVEL:     cur_static_level = val[4:0];
			REG_SPOTSTART: cur_spot_start = val[6:0];
			REG_PEAK:      cur_peak = val[4:0];
			REG_SPOTINT:   cur_spot_int = val[6:0];
			REG_FADEINT:   cur_fade_int = val[9:0];
			default: ;
		endcase
	endtask

	task automatic read_some(input int n);
		for (int i = 0; i < n; i++)
			send_item(OP_READ, 7'($urandom_range(0, 127)), 24'($urandom));
	endtask

	// Directed: every operation, read extremes, unknown operation, all four modes.
	task automatic test_directed();
		send_item(OP_READ, 7'd0, 24'hffffff);
		send_item(OP_READ, 7'd127, 24'h000000);
		send_item(OP_NONE, 7'h7f, 24'hffffff);
		send_item(OP_TICK, 7'h55, 24'haaaaaa);
		send_item(OP_APPLY, 7'd0, 24'd0);
		send_item(OP_READ, 7'd64, 24'd0);
		drain_results();
		write_reg(REG_MODE, 24'(MODE_DARK));
		send_item(OP_APPLY, 7'd0, 24'd0);
		send_item(OP_READ, 7'd5, 24'd0);
		drain_results();
		write_reg(REG_MODE, 24'(MODE_STATIC));
		write_reg(REG_COLOR, 24'hffffff);
		write_reg(REG_LEVEL, 24'd31);
		send_item(OP_APPLY, 7'd0, 24'd0);
		send_item(OP_READ, 7'd127, 24'd0);
		drain_results();
		write_reg(REG_MODE, 24'(MODE_MOVING));
		write_reg(REG_SPOTSTART, 24'd127);
		write_reg(REG_PEAK, 24'd31);
		write_reg(REG_SPOTINT, 24'd0);
		send_item(OP_APPLY, 7'd0, 24'd0);
		send_item(OP_TICK, 7'd0, 24'd0);
		send_item(OP_READ, 7'd100, 24'd0);
		drain_results();
		write_reg(REG_MODE, 24'(MODE_FADE));
		write_reg(REG_FADEINT, 24'd1023);
		send_item(OP_APPLY, 7'd0, 24'd0);
		send_item(OP_TICK, 7'd0, 24'd0);
		drain_results();
	endtask

	// Spot sweep in moving mode; with short intervals the spot runs off the end and the
	// fade-out and fade-in phases follow.
	task automatic test_spot_sweep(input int n, input int interval, input int peak,
			input int start);
		int r;
		write_reg(REG_MODE, 24'(MODE_MOVING));
		write_reg(REG_SPOTINT, 24'(interval));
		write_reg(REG_PEAK, 24'(peak));
		write_reg(REG_SPOTSTART, 24'(start));
		send_item(OP_APPLY, 7'($urandom), 24'($urandom));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) send_item(OP_TICK, 7'($urandom), 24'($urandom));
			else if (r < 96) send_item(OP_READ, 7'($urandom), 24'($urandom));
			else if (r < 98) send_item(OP_NONE, 7'($urandom), 24'($urandom));
			else send_item(OP_APPLY, 7'($urandom), 24'($urandom));
		end
		drain_results();
	endtask

	task automatic test_color_fade(input int n, input int interval);
		write_reg(REG_MODE, 24'(MODE_FADE));
		write_reg(REG_FADEINT, 24'(interval));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) != 0) send_item(OP_TICK, 7'($urandom), 24'($urandom));
			else send_item(OP_READ, 7'($urandom), 24'($urandom));
		end
		drain_results();
	endtask

	task automatic test_static_and_off();
		for (int k = 0; k < 6; k++) begin
			write_reg(REG_MODE, 24'($urandom_range(0, 1)));
			write_reg(REG_COLOR, 24'($urandom));
			write_reg(REG_LEVEL, 24'($urandom_range(0, 31)));
			send_item(OP_APPLY, 7'($urandom), 24'($urandom));
			read_some(8);
			send_item(OP_TICK, 7'($urandom), 24'($urandom));
			drain_results();
		end
	endtask

	// Receiver holds off for a long stretch while the sender offers items without gaps,
	// then the sender pauses until every result is back.
	task automatic test_backpressure();
		rx_hold = 1'b1;
		tx_no_gaps = 1'b1;
		fork
			read_some(12);
			begin
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
		join
		tx_no_gaps = 1'b0;
		drain_results();
	endtask

	// Result checker.
	always @(posedge clk) begin
		strip_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tdata[32]};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: word %h redrawn %b",
						got.frame_word, got.redrawn);
			end else begin
				want = pending_results.pop_front();
				if (got.frame_word !== want.frame_word || got.redrawn !== want.redrawn) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected word %h redrawn %b, got %h %b",
							want.frame_word, want.redrawn, got.frame_word, got.redrawn);
				end
			end
		end
	end

	// Receiver readiness: random stalls, honoring a requested hold-off or a no-stall mode.
	always @(posedge clk or negedge arst_n) begin
		int stall;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (rx_never_stall) begin
			m_axis_tready <= 1'b1;
		end else begin
			stall = pick_gap();
			m_axis_tready <= (stall == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	// Watchdog: counts cycles without any transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		rx_hold = 1'b0;
		rx_never_stall = 1'b0;
		tx_no_gaps = 1'b0;
		cur_mode = MODE_STATIC;
		cur_color = '0;
		cur_static_level = LevelReset;
		cur_spot_start = '0;
		cur_peak = 5'd6;
		cur_spot_int = 7'd50;
		cur_fade_int = 10'd50;
		for (int i = 0; i < NumLeds; i++) levels[i] = LevelReset;
		strip_rgb = '0;
		ms_count = '0;
		ramp_up = 1'b1;
		in_fade_in = 1'b0;
		in_fade_out = 1'b0;
		spot_at = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_static_and_off();
		test_backpressure();
		test_spot_sweep(320, 1, 31, 100);
		rx_never_stall = 1'b1;
		test_spot_sweep(260, 2, 6, 0);
		rx_never_stall = 1'b0;
		test_spot_sweep(120, 1, 0, 127);
		test_spot_sweep(60, 100, 15, 50);
		test_color_fade(440, 1);
		test_color_fade(80, 3);
		test_static_and_off();
		test_backpressure();

		drain_results();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== led_strip_effect_engine.f =====
hdl/lse_pkg.sv
hdl/lse_level_walker.sv
hdl/led_strip_effect_engine.sv
verif/tb_led_strip_effect_engine.sv
